@@ hdl/vlce_pkg.sv @@
// Shared constants, types and address helpers for the lag covariance engine.
`timescale 1ns / 1ps
package vlce_pkg;

    localparam int R_MAX = 4;
    localparam int P_MAX = 4;
    localparam int Q_MAX = 4;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 9;
    localparam int MEM_DEPTH = 512;
    localparam int PROD_W = 64;
    localparam int TERM_W = 48;
    localparam int ACC_W = 53;

    localparam logic [ADDR_W-1:0] BASE_A = 9'd0;
    localparam logic [ADDR_W-1:0] BASE_B = 9'd64;
    localparam logic [ADDR_W-1:0] BASE_S = 9'd128;
    localparam logic [ADDR_W-1:0] BASE_BS = 9'd144;
    localparam logic [ADDR_W-1:0] BASE_C = 9'd224;
    localparam logic [ADDR_W-1:0] BASE_G = 9'd304;
    localparam logic [ADDR_W-1:0] BASE_W = 9'd384;

    localparam logic [2:0] FUNC_LOAD_A = 3'd0;
    localparam logic [2:0] FUNC_LOAD_B = 3'd1;
    localparam logic [2:0] FUNC_LOAD_S = 3'd2;
    localparam logic [2:0] FUNC_COMPUTE = 3'd3;
    localparam logic [2:0] FUNC_READ = 3'd4;

    localparam logic [1:0] KIND_C = 2'd0;
    localparam logic [1:0] KIND_G = 2'd1;
    localparam logic [1:0] KIND_W = 2'd2;

    localparam logic [1:0] CFG_DIMENSION = 2'd0;
    localparam logic [1:0] CFG_AR_ORDER = 2'd1;
    localparam logic [1:0] CFG_MA_ORDER = 2'd2;

    typedef struct packed {
        logic init_load;
        logic init_en;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    function automatic logic [ADDR_W-1:0] maddr(
        input logic [ADDR_W-1:0] base,
        input logic [2:0]        lag,
        input logic [1:0]        rw,
        input logic [1:0]        cl
    );
        maddr = base + {2'b00, lag, 4'b0000} + {5'b00000, rw, cl};
    endfunction

endpackage

@@ hdl/vlce_mem.sv @@
// Matrix store: one write port and two registered read ports.
`timescale 1ns / 1ps
module vlce_mem
    import vlce_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ hdl/vlce_mac.sv @@
// Multiply, round, accumulate and saturate datapath.
`timescale 1ns / 1ps
module vlce_mac
    import vlce_pkg::*;
(
    input  logic              clk,
    input  mac_ctrl_t         ctrl,
    input  logic [DATA_W-1:0] op_a,
    input  logic [DATA_W-1:0] op_b,
    output logic [DATA_W-1:0] sat_value,
    output logic              sat_ovf
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [TERM_W-1:0] term;
    logic                     fits;

    assign prod_rnd = prod_reg + 64'sd32768;
    assign term = prod_rnd[PROD_W-1:16];
    assign fits = (&acc_reg[ACC_W-1:DATA_W-1]) | ~(|acc_reg[ACC_W-1:DATA_W-1]);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= $signed(op_a) * $signed(op_b);
        end
        if (ctrl.init_load)
        begin
            acc_reg <= ctrl.init_en ? {{(ACC_W-DATA_W){op_a[DATA_W-1]}}, op_a}
                                    : '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
        end
    end

    always_comb
    begin
        sat_ovf = ~fits;
        if (fits)
        begin
            sat_value = acc_reg[DATA_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_value = 32'h8000_0000;
        end
        else
        begin
            sat_value = 32'h7FFF_FFFF;
        end
    end

endmodule

@@ hdl/varma_lag_covariance_engine_unit.sv @@
// Top level: configuration, item handshake, compute sequencer and result register.
`timescale 1ns / 1ps
// All matrices live in one 512-entry memory with two registered read ports. A load item
// is written in the cycle it is accepted. A read item reads the memory on acceptance and
// presents its element through the output register once that register is free. A compute
// item walks every stored element of B*Sig, C, G and W in turn. Each element reads its
// starting term, captures it, runs its product terms (read both operands, multiply, round
// and add), and is then saturated and written back; the done item is posted at the end.
// With dimension r and orders p and q there are 4*(q+1)*r*r stored elements and
// r*r*r*(q + q*(q+1) + sum over j=1..q of min(p,j)) product terms. All work is bound by
// the single multiply-accumulate unit and the memory read port pair. Loads and reads are
// taken only while no compute or read is running; results wait in an output register
// while further loads are accepted.
module varma_lag_covariance_engine_unit
    import vlce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic [2:0]         lag,
    input  logic [1:0]         matrix_kind,
    input  logic [1:0]         row,
    input  logic [1:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               result_kind,
    output logic signed [31:0] read_value,
    output logic               overflow
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RD_WAIT   = 4'd1;
    localparam logic [3:0] S_INIT_RD   = 4'd2;
    localparam logic [3:0] S_INIT_WAIT = 4'd3;
    localparam logic [3:0] S_TERM_RD   = 4'd4;
    localparam logic [3:0] S_TERM_WAIT = 4'd5;
    localparam logic [3:0] S_TERM_ACC  = 4'd6;
    localparam logic [3:0] S_STORE     = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    localparam logic [2:0] PH_COPY_BS = 3'd0;
    localparam logic [2:0] PH_COPY_C  = 3'd1;
    localparam logic [2:0] PH_BS      = 3'd2;
    localparam logic [2:0] PH_C       = 3'd3;
    localparam logic [2:0] PH_G       = 3'd4;
    localparam logic [2:0] PH_W       = 3'd5;

    logic [2:0] dimension_reg, ar_order_reg, ma_order_reg;
    logic [3:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [2:0] j_reg, j_next;
    logic [2:0] i_reg, i_next;
    logic [1:0] a_reg, a_next;
    logic [1:0] b_reg, b_next;
    logic [1:0] k_reg, k_next;
    logic       overflow_reg, overflow_next;
    logic       rd_ok_reg, rd_ok_next;
    logic       out_valid_reg, out_valid_next;
    logic       result_kind_reg, result_kind_next;
    logic       result_ovf_reg, result_ovf_next;
    logic [31:0] read_value_reg, read_value_next;

    logic [2:0] r_eff, p_eff, q_eff, ilo, ihi;
    logic [1:0] rm1;
    logic       has_init, term_any, out_free, accept;
    logic       mem_we, mem_re;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b, dest_addr, init_addr, op_a_addr, op_b_addr;
    logic [ADDR_W-1:0] rd_base;
    logic [DATA_W-1:0] wdata, rdata_a, rdata_b, sat_value;
    logic       sat_ovf;
    mac_ctrl_t  mac_ctrl;

    assign r_eff = (dimension_reg == 3'd0) ? 3'd1 :
                   (dimension_reg > 3'(R_MAX)) ? 3'(R_MAX) : dimension_reg;
    assign p_eff = (ar_order_reg > 3'(P_MAX)) ? 3'(P_MAX) : ar_order_reg;
    assign q_eff = (ma_order_reg > 3'(Q_MAX)) ? 3'(Q_MAX) : ma_order_reg;
    assign rm1 = 2'(r_eff - 3'd1);

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign read_value = read_value_reg;
    assign overflow = result_ovf_reg;

    always_comb
    begin
        has_init = 1'b1;
        ilo = 3'd1;
        ihi = 3'd1;
        term_any = 1'b1;
        init_addr = maddr(BASE_BS, j_reg, a_reg, b_reg);
        op_a_addr = '0;
        op_b_addr = '0;
        dest_addr = '0;
        case (phase_reg)
            PH_COPY_BS:
            begin
                init_addr = maddr(BASE_S, 3'd0, a_reg, b_reg);
                dest_addr = maddr(BASE_BS, 3'd0, a_reg, b_reg);
                term_any = 1'b0;
            end
            PH_COPY_C:
            begin
                init_addr = maddr(BASE_S, 3'd0, a_reg, b_reg);
                dest_addr = maddr(BASE_C, 3'd0, a_reg, b_reg);
                term_any = 1'b0;
            end
            PH_BS:
            begin
                has_init = 1'b0;
                op_a_addr = maddr(BASE_B, j_reg - 3'd1, a_reg, k_reg);
                op_b_addr = maddr(BASE_S, 3'd0, k_reg, b_reg);
                dest_addr = maddr(BASE_BS, j_reg, a_reg, b_reg);
            end
            PH_C:
            begin
                ihi = (p_eff < j_reg) ? p_eff : j_reg;
                term_any = (p_eff != 3'd0);
                op_a_addr = maddr(BASE_A, i_reg - 3'd1, a_reg, k_reg);
                op_b_addr = maddr(BASE_C, j_reg - i_reg, k_reg, b_reg);
                dest_addr = maddr(BASE_C, j_reg, a_reg, b_reg);
            end
            PH_G:
            begin
                ilo = j_reg + 3'd1;
                ihi = q_eff;
                term_any = (j_reg < q_eff);
                op_a_addr = maddr(BASE_B, i_reg - 3'd1, a_reg, k_reg);
                op_b_addr = maddr(BASE_C, i_reg - j_reg, b_reg, k_reg);
                dest_addr = maddr(BASE_G, j_reg, a_reg, b_reg);
            end
            PH_W:
            begin
                ilo = j_reg + 3'd1;
                ihi = q_eff;
                term_any = (j_reg < q_eff);
                op_a_addr = maddr(BASE_BS, i_reg, a_reg, k_reg);
                op_b_addr = maddr(BASE_B, i_reg - j_reg - 3'd1, b_reg, k_reg);
                dest_addr = maddr(BASE_W, j_reg, a_reg, b_reg);
            end
            default:
            begin
                term_any = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (matrix_kind)
            KIND_C:  rd_base = BASE_C;
            KIND_G:  rd_base = BASE_G;
            default: rd_base = BASE_W;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        j_next = j_reg;
        i_next = i_reg;
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        overflow_next = overflow_reg;
        rd_ok_next = rd_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_kind_next = result_kind_reg;
        result_ovf_next = result_ovf_reg;
        read_value_next = read_value_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr = dest_addr;
        wdata = sat_value;
        raddr_a = op_a_addr;
        raddr_b = op_b_addr;
        mac_ctrl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_LOAD_A:
                        begin
                            mem_we = (lag >= 3'd1) && (lag <= 3'(P_MAX));
                            waddr = maddr(BASE_A, lag - 3'd1, row, col);
                            wdata = value;
                        end
                        FUNC_LOAD_B:
                        begin
                            mem_we = (lag >= 3'd1) && (lag <= 3'(Q_MAX));
                            waddr = maddr(BASE_B, lag - 3'd1, row, col);
                            wdata = value;
                        end
                        FUNC_LOAD_S:
                        begin
                            mem_we = 1'b1;
                            waddr = maddr(BASE_S, 3'd0, row, col);
                            wdata = value;
                        end
                        FUNC_COMPUTE:
                        begin
                            phase_next = PH_COPY_BS;
                            j_next = 3'd0;
                            a_next = 2'd0;
                            b_next = 2'd0;
                            state_next = S_INIT_RD;
                        end
                        FUNC_READ:
                        begin
                            mem_re = 1'b1;
                            raddr_a = maddr(rd_base, lag, row, col);
                            rd_ok_next = (lag <= q_eff) && ({1'b0, row} < r_eff)
                                         && ({1'b0, col} < r_eff)
                                         && (matrix_kind != 2'd3);
                            state_next = S_RD_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_kind_next = 1'b0;
                    result_ovf_next = overflow_reg;
                    read_value_next = rd_ok_reg ? rdata_a : '0;
                    state_next = S_IDLE;
                end
            end
            S_INIT_RD:
            begin
                mem_re = 1'b1;
                raddr_a = init_addr;
                state_next = S_INIT_WAIT;
            end
            S_INIT_WAIT:
            begin
                mac_ctrl.init_load = 1'b1;
                mac_ctrl.init_en = has_init;
                i_next = ilo;
                k_next = 2'd0;
                state_next = term_any ? S_TERM_RD : S_STORE;
            end
            S_TERM_RD:
            begin
                mem_re = 1'b1;
                state_next = S_TERM_WAIT;
            end
            S_TERM_WAIT:
            begin
                mac_ctrl.mul_en = 1'b1;
                state_next = S_TERM_ACC;
            end
            S_TERM_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next = S_TERM_RD;
                if (k_reg == rm1)
                begin
                    k_next = 2'd0;
                    if (i_reg == ihi)
                    begin
                        state_next = S_STORE;
                    end
                    else
                    begin
                        i_next = i_reg + 3'd1;
                    end
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_STORE:
            begin
                mem_we = 1'b1;
                overflow_next = overflow_reg | sat_ovf;
                state_next = S_INIT_RD;
                if (b_reg == rm1)
                begin
                    b_next = 2'd0;
                    if (a_reg == rm1)
                    begin
                        a_next = 2'd0;
                        case (phase_reg)
                            PH_COPY_BS:
                            begin
                                phase_next = PH_COPY_C;
                            end
                            PH_COPY_C:
                            begin
                                if (q_eff != 3'd0)
                                begin
                                    phase_next = PH_BS;
                                    j_next = 3'd1;
                                end
                                else
                                begin
                                    phase_next = PH_G;
                                end
                            end
                            PH_BS:
                            begin
                                phase_next = PH_C;
                            end
                            PH_C:
                            begin
                                if (j_reg == q_eff)
                                begin
                                    phase_next = PH_G;
                                    j_next = 3'd0;
                                end
                                else
                                begin
                                    phase_next = PH_BS;
                                    j_next = j_reg + 3'd1;
                                end
                            end
                            PH_G:
                            begin
                                if (j_reg == q_eff)
                                begin
                                    phase_next = PH_W;
                                    j_next = 3'd0;
                                end
                                else
                                begin
                                    j_next = j_reg + 3'd1;
                                end
                            end
                            default:
                            begin
                                if (j_reg == q_eff)
                                begin
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    j_next = j_reg + 3'd1;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        a_next = a_reg + 2'd1;
                    end
                end
                else
                begin
                    b_next = b_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_kind_next = 1'b1;
                    result_ovf_next = overflow_reg;
                    read_value_next = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= 3'd1;
            ar_order_reg <= 3'd0;
            ma_order_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIMENSION: dimension_reg <= cfg_data;
                CFG_AR_ORDER:  ar_order_reg <= cfg_data;
                CFG_MA_ORDER:  ma_order_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_COPY_BS;
            j_reg <= '0;
            i_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            k_reg <= '0;
            overflow_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            result_kind_reg <= 1'b0;
            result_ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            j_reg <= j_next;
            i_reg <= i_next;
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
            overflow_reg <= overflow_next;
            rd_ok_reg <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            result_kind_reg <= result_kind_next;
            result_ovf_reg <= result_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
    end

    vlce_mem u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (mem_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    vlce_mac u_mac (
        .clk       (clk),
        .ctrl      (mac_ctrl),
        .op_a      (rdata_a),
        .op_b      (rdata_b),
        .sat_value (sat_value),
        .sat_ovf   (sat_ovf)
    );

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared outside reset");

    a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_WAIT) |-> !mem_we)
        else $error("memory written while a read item is pending");

    a_compute_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TERM_ACC) |-> (k_reg <= rm1))
        else $error("product index beyond matrix dimension");

endmodule

@@ tb/varma_lag_covariance_engine_unit_tb.sv @@
// Self-checking testbench for the lag covariance engine: predicts C, G and W reads and checks each result.
`timescale 1ns / 1ps
module varma_lag_covariance_engine_unit_tb;
    import vlce_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] data;
        logic        ovf;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [2:0] func;
    logic [2:0] lag;
    logic [1:0] matrix_kind;
    logic [1:0] row;
    logic [1:0] col;
    logic signed [31:0] value;
    logic out_valid;
    logic out_ready;
    logic result_kind;
    logic signed [31:0] read_value;
    logic overflow;

    logic signed [31:0] ar_m [P_MAX][R_MAX][R_MAX];
    logic signed [31:0] ma_m [Q_MAX][R_MAX][R_MAX];
    logic signed [31:0] sig_m [R_MAX][R_MAX];
    logic signed [31:0] bs_m [Q_MAX+1][R_MAX][R_MAX];
    logic signed [31:0] c_m [Q_MAX+1][R_MAX][R_MAX];
    logic signed [31:0] g_m [Q_MAX+1][R_MAX][R_MAX];
    logic signed [31:0] w_m [Q_MAX+1][R_MAX][R_MAX];
    logic sticky_ovf;
    logic [2:0] dim_reg;
    logic [2:0] p_reg;
    logic [2:0] q_reg;
    bit computed;

    result_t expected_results[$];
    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    varma_lag_covariance_engine_unit DUT (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 8000000)
        begin
            $display("varma_lag_covariance_engine_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic longint qprod(logic signed [31:0] a, logic signed [31:0] b);
        longint x;
        x = longint'(a) * longint'(b) + 32768;
        return x >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(longint x);
        if (x > 64'sd2147483647)
        begin
            sticky_ovf = 1;
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648)
        begin
            sticky_ovf = 1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic void predict_covariances();
        int r;
        int p;
        int q;
        longint s;
        longint sw;
        r = (dim_reg < 1) ? 1 : ((dim_reg > R_MAX) ? R_MAX : dim_reg);
        p = (p_reg > P_MAX) ? P_MAX : p_reg;
        q = (q_reg > Q_MAX) ? Q_MAX : q_reg;
        for (int a = 0; a < R_MAX; a++)
            for (int b = 0; b < R_MAX; b++)
            begin
                bs_m[0][a][b] = sig_m[a][b];
                c_m[0][a][b] = sig_m[a][b];
            end
        for (int j = 1; j <= q; j++)
        begin
            for (int a = 0; a < r; a++)
                for (int b = 0; b < r; b++)
                begin
                    s = 0;
                    for (int k = 0; k < r; k++)
                        s += qprod(ma_m[j-1][a][k], sig_m[k][b]);
                    bs_m[j][a][b] = sat32(s);
                end
            for (int a = 0; a < r; a++)
                for (int b = 0; b < r; b++)
                begin
                    s = bs_m[j][a][b];
                    for (int i = 1; i <= p && i <= j; i++)
                        for (int k = 0; k < r; k++)
                            s += qprod(ar_m[i-1][a][k], c_m[j-i][k][b]);
                    c_m[j][a][b] = sat32(s);
                end
        end
        for (int j = 0; j <= q; j++)
            for (int a = 0; a < r; a++)
                for (int b = 0; b < r; b++)
                begin
                    s = bs_m[j][a][b];
                    sw = s;
                    for (int i = j + 1; i <= q; i++)
                        for (int k = 0; k < r; k++)
                        begin
                            s += qprod(ma_m[i-1][a][k], c_m[i-j][b][k]);
                            sw += qprod(bs_m[i][a][k], ma_m[i-j-1][b][k]);
                        end
                    g_m[j][a][b] = sat32(s);
                    w_m[j][a][b] = sat32(sw);
                end
    endfunction

    function automatic void predict_item(logic [2:0] f, logic [2:0] lg, logic [1:0] kd,
                                         logic [1:0] rw, logic [1:0] cl, logic [31:0] v);
        result_t res;
        int r;
        int q;
        r = (dim_reg < 1) ? 1 : ((dim_reg > R_MAX) ? R_MAX : dim_reg);
        q = (q_reg > Q_MAX) ? Q_MAX : q_reg;
        if (f == FUNC_LOAD_A)
        begin
            if (lg >= 1 && lg <= P_MAX)
                ar_m[lg-1][rw][cl] = v;
        end
        else if (f == FUNC_LOAD_B)
        begin
            if (lg >= 1 && lg <= Q_MAX)
                ma_m[lg-1][rw][cl] = v;
        end
        else if (f == FUNC_LOAD_S)
            sig_m[rw][cl] = v;
        else if (f == FUNC_COMPUTE)
        begin
            predict_covariances();
            res.kind = 1;
            res.data = 0;
            res.ovf = sticky_ovf;
            expected_results.push_back(res);
        end
        else if (f == FUNC_READ)
        begin
            res.kind = 0;
            res.data = 0;
            res.ovf = sticky_ovf;
            if (lg <= q && rw < r && cl < r)
            begin
                if (kd == KIND_C)
                    res.data = c_m[lg][rw][cl];
                else if (kd == KIND_G)
                    res.data = g_m[lg][rw][cl];
                else if (kd == KIND_W)
                    res.data = w_m[lg][rw][cl];
            end
            expected_results.push_back(res);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d value=%h", result_kind, read_value);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result_kind !== exp_res.kind || read_value !== exp_res.data
                    || overflow !== exp_res.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result: expected %0d/%h/%0d got %0d/%h/%0d",
                                 exp_res.kind, exp_res.data, exp_res.ovf,
                                 result_kind, read_value, overflow);
                end
            end
        end
    end

    task automatic send_item(logic [2:0] f, logic [2:0] lg, logic [1:0] kd,
                             logic [1:0] rw, logic [1:0] cl, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        func <= f;
        lag <= lg;
        matrix_kind <= kd;
        row <= rw;
        col <= cl;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(f, lg, kd, rw, cl, v);
    endtask

    task automatic wait_drain();
        in_valid <= 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [2:0] d);
        wait_drain();
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_DIMENSION)
            dim_reg = d;
        else if (idx == CFG_AR_ORDER)
            p_reg = d;
        else
            q_reg = d;
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $urandom_range(65536 * 3) - 65536 * 3 / 2;
        endcase
    endfunction

    // fill every matrix element so no compute touches an unwritten entry
    task automatic load_all(int mode);
        for (int l = 1; l <= P_MAX; l++)
            for (int a = 0; a < R_MAX; a++)
                for (int b = 0; b < R_MAX; b++)
                    send_item(FUNC_LOAD_A, 3'(l), 2'($urandom), 2'(a), 2'(b),
                              rand_value(mode));
        for (int l = 1; l <= Q_MAX; l++)
            for (int a = 0; a < R_MAX; a++)
                for (int b = 0; b < R_MAX; b++)
                    send_item(FUNC_LOAD_B, 3'(l), 2'($urandom), 2'(a), 2'(b),
                              rand_value(mode));
        for (int a = 0; a < R_MAX; a++)
            for (int b = 0; b < R_MAX; b++)
                send_item(FUNC_LOAD_S, 3'($urandom), 2'($urandom), 2'(a), 2'(b),
                          rand_value(mode));
    endtask

    task automatic read_all();
        for (int l = 0; l < 6; l++)
            for (int k = 0; k < 4; k++)
                send_item(FUNC_READ, 3'(l), 2'(k), 2'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic test_directed();
        load_all(3);
        send_item(FUNC_COMPUTE, 0, 0, 0, 0, 0);
        send_item(FUNC_READ, 0, KIND_C, 0, 0, 0);
        send_item(FUNC_READ, 0, KIND_G, 0, 0, 0);
        send_item(FUNC_READ, 0, KIND_W, 0, 0, 0);
        send_item(FUNC_READ, 0, 3, 0, 0, 0);
        send_item(FUNC_READ, 1, KIND_C, 0, 0, 0);
        send_item(FUNC_READ, 0, KIND_C, 3, 3, 0);
        send_item(FUNC_LOAD_A, 0, 0, 0, 0, 32'h12345678);
        send_item(FUNC_LOAD_A, 5, 0, 0, 0, 32'h12345678);
        send_item(FUNC_LOAD_B, 7, 0, 0, 0, 32'h12345678);
        send_item(5, 0, 0, 0, 0, 0);
        send_item(6, 7, 3, 3, 3, 32'hffffffff);
        send_item(7, 0, 0, 0, 0, 0);
        write_cfg(CFG_DIMENSION, 4);
        write_cfg(CFG_AR_ORDER, 4);
        write_cfg(CFG_MA_ORDER, 4);
        send_item(FUNC_COMPUTE, 0, 0, 0, 0, 0);
        read_all();
    endtask

    task automatic test_random_phases(int first_ph, int last_ph);
        int mode;
        for (int ph = first_ph; ph <= last_ph; ph++)
        begin
            write_cfg(CFG_DIMENSION,
                      (ph == 0) ? 3'd0 : ((ph == 1) ? 3'd7 : 3'($urandom_range(1, 4))));
            write_cfg(CFG_AR_ORDER,
                      (ph == 2) ? 3'd7 : ((ph == 3) ? 3'd0 : 3'($urandom_range(0, 4))));
            write_cfg(CFG_MA_ORDER,
                      (ph == 4) ? 3'd7 : ((ph == 5) ? 3'd0 : 3'($urandom_range(0, 4))));
            mode = (ph == 6) ? 1 : ((ph == 7) ? 2 : ((ph == 8) ? 0 : 3));
            load_all(mode);
            send_item(FUNC_COMPUTE, 3'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                      $urandom);
            for (int n = 0; n < 30; n++)
                send_item(FUNC_READ, 3'($urandom_range(0, 5)), 2'($urandom), 2'($urandom),
                          2'($urandom), $urandom);
            for (int n = 0; n < 6; n++)
                send_item($urandom_range(0, 7) == 3 ? 3'd4 : 3'($urandom_range(0, 7)),
                          3'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), $urandom);
            send_item(FUNC_COMPUTE, 0, 0, 0, 0, 0);
            read_all();
            if (ph == 3)
                wait_drain();
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        func = 0;
        lag = 0;
        matrix_kind = 0;
        row = 0;
        col = 0;
        value = 0;
        out_ready = 0;
        cycles = 0;
        mismatches = 0;
        sticky_ovf = 0;
        dim_reg = 1;
        p_reg = 0;
        q_reg = 0;
        send_idle_pct = 18;
        recv_idle_pct = 61;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random_phases(0, 3);
        send_idle_pct = 61;
        recv_idle_pct = 18;
        test_random_phases(4, 7);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phases(8, 11);
        wait_drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("varma_lag_covariance_engine_unit: match");
        else
            $display("varma_lag_covariance_engine_unit: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/vlce_pkg.sv
hdl/vlce_mem.sv
hdl/vlce_mac.sv
hdl/varma_lag_covariance_engine_unit.sv
tb/varma_lag_covariance_engine_unit_tb.sv
